### src/generational_handle_table_assert.svh
// Assertion macros used by the handle table RTL.
`ifndef GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define GHT_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("handle table check failed (same cycle)");
`define GHT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("handle table check failed (next cycle)");
`else
`define GHT_ASSERT_SAME(label, clk, rst, a, b)
`define GHT_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

### src/ght_pkg.sv
// Package with types and constants of the generational handle table.
package ght_pkg;

  localparam int SLOT_COUNT_DEF   = 128;
  localparam int INDEX_BITS_DEF   = 8;
  localparam int GEN_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int HOUT_W   = 24;
  localparam int VALUE_W  = 32;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FONT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IMAGE  = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

### src/generational_handle_table.sv
// Generational handle table: add, lookup and clear-all over a slot memory.
// Each item reads its slot from the slot memory at the accepting edge; an add writes the slot
// back in the execute state, when the result is loaded into the output register.
// No new item is accepted until the current one leaves execution, which the read-then-write-back
// of the single slot memory sets; a stalled output holds the item in execution.
// Reset (synchronous) clears the busy and generation-written flags at once; no clearing pass.
`include "generational_handle_table_assert.svh"

module generational_handle_table #(
  parameter int SLOT_COUNT   = ght_pkg::SLOT_COUNT_DEF,
  parameter int INDEX_BITS   = ght_pkg::INDEX_BITS_DEF,
  parameter int GEN_BITS     = ght_pkg::GEN_BITS_DEF,
  parameter int PAYLOAD_BITS = ght_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         opcode,
  input  logic [ght_pkg::KIND_W-1:0]         kind,
  input  logic [31:0]                        payload,
  input  logic                               owned_present,
  input  logic signed [ght_pkg::HANDLE_W-1:0] handle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ght_pkg::HOUT_W-1:0]         handle_out,
  output logic                               found,
  output logic [ght_pkg::VALUE_W-1:0]        value
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RGEN_W = ght_pkg::HANDLE_W - INDEX_BITS;
  localparam int MEM_W = PAYLOAD_BITS + ght_pkg::KIND_W + GEN_BITS;

  ght_pkg::state_t state, state_next;

  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] gen_written;

  logic accept;
  logic exec_done;

  // Decode of the incoming beat.
  ght_pkg::opcode_t            in_op;
  logic [PAYLOAD_BITS+31:0]    pay_ext;
  logic [PAYLOAD_BITS-1:0]     pay_trunc;
  logic [INDEX_BITS-1:0]       enc;
  logic [INDEX_BITS-1:0]       enc_m1;
  logic [IDX_W-1:0]            look_idx;
  logic [IDX_W-1:0]            free_idx;
  logic                        any_free;
  logic                        add_ok;
  logic                        look_ok;
  logic [IDX_W-1:0]            rd_idx;

  // Item under execution.
  ght_pkg::opcode_t            ex_op;
  logic [ght_pkg::KIND_W-1:0]  ex_kind;
  logic [PAYLOAD_BITS-1:0]     ex_pay;
  logic [IDX_W-1:0]            ex_idx;
  logic                        ex_ok;
  logic [RGEN_W-1:0]           ex_rgen;

  logic [MEM_W-1:0]            rd_data;
  logic [MEM_W-1:0]            wr_data;
  logic [GEN_BITS-1:0]         rd_gen;
  logic [ght_pkg::KIND_W-1:0]  rd_kind;
  logic [PAYLOAD_BITS-1:0]     rd_pay;
  logic [GEN_BITS-1:0]         gen_cur;
  logic [GEN_BITS-1:0]         gen_inc;
  logic [GEN_BITS-1:0]         gen_new;
  logic [INDEX_BITS-1:0]       enc_new;
  logic [ght_pkg::HOUT_W+GEN_BITS+INDEX_BITS-1:0] hout_ext;
  logic [PAYLOAD_BITS+31:0]    val_ext;
  logic                        lookup_hit;
  logic                        add_commit;
  logic                        clear_commit;

  assign accept = in_valid && !in_stall;

  assign in_op     = ght_pkg::opcode_t'(opcode);
  assign pay_ext   = {{PAYLOAD_BITS{1'b0}}, payload};
  assign pay_trunc = pay_ext[PAYLOAD_BITS-1:0];
  assign enc       = handle[INDEX_BITS-1:0];
  assign enc_m1    = enc - 1'b1;
  assign look_idx  = enc_m1[IDX_W-1:0];

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_idx = IDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign add_ok = (kind != ght_pkg::KIND_NONE) && (pay_trunc != '0) && any_free &&
                  !(((kind == ght_pkg::KIND_FONT) || (kind == ght_pkg::KIND_IMAGE)) &&
                    !owned_present);

  // A nonzero index field also rules out a zero handle.
  assign look_ok = !handle[ght_pkg::HANDLE_W-1] && (kind != ght_pkg::KIND_NONE) &&
                   (enc != '0) && (enc <= INDEX_BITS'(SLOT_COUNT));

  assign rd_idx = (in_op == ght_pkg::OP_ADD) ? free_idx : look_idx;

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_op   <= in_op;
      ex_kind <= kind;
      ex_pay  <= pay_trunc;
      ex_idx  <= rd_idx;
      ex_ok   <= (in_op == ght_pkg::OP_ADD) ? add_ok : look_ok;
      ex_rgen <= handle[ght_pkg::HANDLE_W-1:INDEX_BITS];
    end
  end

  ght_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W),
    .WIDTH (MEM_W)
  ) u_slot_mem (
    .clk   (clk),
    .we    (add_commit),
    .waddr (ex_idx),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign rd_gen  = rd_data[GEN_BITS-1:0];
  assign rd_kind = rd_data[GEN_BITS +: ght_pkg::KIND_W];
  assign rd_pay  = rd_data[MEM_W-1 -: PAYLOAD_BITS];

  // A generation never written reads as zero.
  assign gen_cur = gen_written[ex_idx] ? rd_gen : '0;
  assign gen_inc = gen_cur + 1'b1;
  assign gen_new = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign enc_new = INDEX_BITS'(ex_idx) + 1'b1;
  assign hout_ext = {{ght_pkg::HOUT_W{1'b0}}, gen_new, enc_new};
  assign val_ext  = {32'b0, rd_pay};
  assign wr_data  = {ex_pay, ex_kind, gen_new};

  assign lookup_hit = (ex_op == ght_pkg::OP_LOOKUP) && ex_ok && busy[ex_idx] &&
                      (rd_kind == ex_kind) && (RGEN_W'(gen_cur) == ex_rgen);

  assign add_commit   = exec_done && (ex_op == ght_pkg::OP_ADD) && ex_ok;
  assign clear_commit = exec_done && (ex_op == ght_pkg::OP_CLEAR);

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ght_pkg::ST_EXEC;
        end
      end
      ght_pkg::ST_EXEC: begin
        if (exec_done) begin
          state_next = ght_pkg::ST_IDLE;
        end
      end
      default: state_next = ght_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall  = 1'b1;
    exec_done = 1'b0;
    unique case (state)
      ght_pkg::ST_IDLE: in_stall = 1'b0;
      ght_pkg::ST_EXEC: exec_done = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ght_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      gen_written <= '0;
    end else if (clear_commit) begin
      busy <= '0;
    end else if (add_commit) begin
      busy[ex_idx]        <= 1'b1;
      gen_written[ex_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      handle_out <= add_commit ? hout_ext[ght_pkg::HOUT_W-1:0] : '0;
      found      <= lookup_hit;
      value      <= lookup_hit ? val_ext[ght_pkg::VALUE_W-1:0] : '0;
    end
  end

  `GHT_ASSERT_NEXT(a_add_marks_busy, clk, rst, add_commit, busy[ex_idx] && gen_written[ex_idx])
  `GHT_ASSERT_NEXT(a_clear_frees_all, clk, rst, clear_commit, busy == '0)
  `GHT_ASSERT_SAME(a_found_no_handle, clk, rst, out_valid && found, handle_out == '0)

endmodule

### src/ght_slot_mem.sv
// Synchronous slot memory with one write port and one registered read port.
module ght_slot_mem #(
  parameter int DEPTH = ght_pkg::SLOT_COUNT_DEF,
  parameter int AW    = 7,
  parameter int WIDTH = 50
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/sv/ght_scoreboard_pkg.sv
// Slot map predictor and result scoreboard for the generational handle table testbench.
package ght_scoreboard_pkg;
  import ght_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  localparam int IDX_W = INDEX_BITS_DEF;
  localparam int GEN_W = GEN_BITS_DEF;

  typedef struct packed {
    logic [HOUT_W-1:0]  handle_out;
    logic               found;
    logic [VALUE_W-1:0] value;
  } table_result_t;

  class slot_map_scoreboard;
    logic [KIND_W-1:0]  slot_kind [SLOTS];
    logic [GEN_W-1:0]   slot_gen [SLOTS];
    logic [VALUE_W-1:0] slot_payload [SLOTS];
    table_result_t      pending_results [$];
    int                 error_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_kind[i] = KIND_NONE;
        slot_gen[i] = '0;
        slot_payload[i] = '0;
      end
      error_count = 0;
    endfunction

    // Applies one accepted request beat to the slot map and queues the result it must produce.
    function table_result_t note_request(opcode_t op, logic [KIND_W-1:0] k,
                                         logic [VALUE_W-1:0] pay, logic owned,
                                         logic [HANDLE_W-1:0] h);
      table_result_t       res;
      int                  slot;
      logic [GEN_W-1:0]    next_gen;
      logic [IDX_W-1:0]    enc;
      logic [HANDLE_W-1:0] gen_field;
      logic [HANDLE_W-1:0] new_handle;
      bit                  claimed;
      res = '0;
      claimed = 1'b0;
      case (op)
        OP_ADD: begin
          if (k != KIND_NONE && pay != '0 && (k == KIND_OBJECT || owned)) begin
            for (slot = 0; slot < SLOTS; slot++) begin
              if (!claimed && slot_kind[slot] == KIND_NONE) begin
                claimed = 1'b1;
                next_gen = slot_gen[slot] + 1'b1;
                // A generation of zero is never handed out.
                if (next_gen == '0) next_gen = GEN_W'(1);
                slot_gen[slot] = next_gen;
                slot_kind[slot] = k;
                slot_payload[slot] = pay;
                new_handle = (HANDLE_W'(next_gen) << IDX_W) | HANDLE_W'(slot + 1);
                res.handle_out = new_handle[HOUT_W-1:0];
              end
            end
          end
        end
        OP_LOOKUP: begin
          enc = h[IDX_W-1:0];
          gen_field = h >> IDX_W;
          slot = int'(enc) - 1;
          if (h != '0 && !h[HANDLE_W-1] && k != KIND_NONE && enc != '0 && slot < SLOTS) begin
            if (slot_kind[slot] == k && HANDLE_W'(slot_gen[slot]) == gen_field) begin
              res.found = 1'b1;
              res.value = slot_payload[slot];
            end
          end
        end
        OP_CLEAR: begin
          for (slot = 0; slot < SLOTS; slot++) slot_kind[slot] = KIND_NONE;
        end
        default: begin
        end
      endcase
      pending_results.push_back(res);
      return res;
    endfunction

    function void check_result(logic [HOUT_W-1:0] h, logic f, logic [VALUE_W-1:0] v);
      table_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: handle_out %h found %b value %h", h, f, v);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (h !== exp_res.handle_out) begin
          $error("handle_out mismatch: expected %h, actual %h", exp_res.handle_out, h);
          error_count++;
        end
        if (f !== exp_res.found) begin
          $error("found mismatch: expected %b, actual %b", exp_res.found, f);
          error_count++;
        end
        if (v !== exp_res.value) begin
          $error("value mismatch: expected %h, actual %h", exp_res.value, v);
          error_count++;
        end
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

endpackage

### tb/sv/generational_handle_table_tb.sv
// Testbench top: drives add, lookup, clear and nop beats into the handle table and checks every result.
module generational_handle_table_tb;
  import ght_pkg::*;
  import ght_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD = 300;
  localparam int ISSUED_MAX = 256;

  typedef struct {
    logic [31:0]       handle;
    logic [KIND_W-1:0] kind;
  } issued_handle_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 opcode = OP_NOP;
  logic [KIND_W-1:0]          kind = KIND_NONE;
  logic [31:0]                payload = '0;
  logic                       owned_present = 1'b0;
  logic signed [HANDLE_W-1:0] handle = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [HOUT_W-1:0]          handle_out;
  logic                       found;
  logic [VALUE_W-1:0]         value;

  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  logic               hold_req = 1'b0;
  logic               hold_seen = 1'b0;
  int                 hold_left = 0;
  int                 cycle_count = 0;
  slot_map_scoreboard sb = new();
  issued_handle_t     issued [$];
  table_result_t      last_result;

  generational_handle_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .kind(kind),
    .payload(payload),
    .owned_present(owned_present),
    .handle(handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .handle_out(handle_out),
    .found(found),
    .value(value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Result side: checks accepted beats, stalls at random, and runs a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(handle_out, found, value);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("generational_handle_table verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] random_payload();
    logic [31:0] p;
    p = $urandom;
    if (p == '0) p = 32'd1;
    return p;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 19) == 0) return KIND_NONE;
    return KIND_W'($urandom_range(KIND_OBJECT, KIND_IMAGE));
  endfunction

  // Offers one beat and returns once it is accepted; valid stays high for a following beat.
  task automatic send_item(input opcode_t op, input logic [KIND_W-1:0] k, input logic [31:0] pay,
                           input logic owned, input logic [31:0] h);
    issued_handle_t entry;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    kind <= k;
    payload <= pay;
    owned_present <= owned;
    handle <= h;
    do @(posedge clk); while (in_stall);
    last_result = sb.note_request(op, k, pay, owned, h);
    if (op == OP_ADD && last_result.handle_out != '0) begin
      entry.handle = 32'(last_result.handle_out);
      entry.kind = k;
      issued.push_back(entry);
      if (issued.size() > ISSUED_MAX) void'(issued.pop_front());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int                r;
    int                sel;
    int                pick;
    int                bitpos;
    logic [31:0]       h;
    logic [KIND_W-1:0] k;
    logic [31:0]       pay;
    r = $urandom_range(0, 99);
    k = pick_kind();
    pay = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    h = $urandom;
    if (r < 47) begin
      send_item(OP_ADD, k, pay, $urandom_range(0, 9) != 0, h);
    end else if (r < 90) begin
      // Mostly handles that were really issued, some stale or damaged, some arbitrary.
      sel = $urandom_range(0, 99);
      if (issued.size() != 0 && sel < 80) begin
        pick = $urandom_range(0, issued.size() - 1);
        h = issued[pick].handle;
        if (sel < 70) k = issued[pick].kind;
        if (sel >= 60 && sel < 70) begin
          bitpos = $urandom_range(0, HOUT_W - 1);
          h[bitpos] = ~h[bitpos];
        end
      end else if (sel < 92) begin
        h = $urandom_range(0, 32'h1FFFF);
      end
      send_item(OP_LOOKUP, k, pay, 1'($urandom_range(0, 1)), h);
    end else if (r < 93) begin
      send_item(OP_CLEAR, k, pay, 1'($urandom_range(0, 1)), h);
    end else begin
      send_item(OP_NOP, k, pay, 1'($urandom_range(0, 1)), h);
    end
  endtask

  task automatic run_directed();
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'd0);
    send_item(OP_ADD, KIND_OBJECT, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_ADD, KIND_FONT, 32'd1, 1'b1, 32'd0);
    send_item(OP_ADD, KIND_IMAGE, 32'h8000_0000, 1'b1, 32'd0);
    // Font and image need owned data; a zero payload or kind never takes a slot.
    send_item(OP_ADD, KIND_FONT, 32'd5, 1'b0, 32'd0);
    send_item(OP_ADD, KIND_IMAGE, 32'd6, 1'b0, 32'd0);
    send_item(OP_ADD, KIND_OBJECT, 32'd0, 1'b1, 32'd0);
    send_item(OP_ADD, KIND_NONE, 32'd7, 1'b1, 32'd0);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0101);
    send_item(OP_LOOKUP, KIND_FONT, 32'd0, 1'b0, 32'h0000_0102);
    send_item(OP_LOOKUP, KIND_IMAGE, 32'd0, 1'b1, 32'h0000_0103);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0102);
    send_item(OP_LOOKUP, KIND_NONE, 32'd0, 1'b0, 32'h0000_0103);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0201);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0100);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0181);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_01FF);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h8000_0101);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h7FFF_FFFF);
    send_item(OP_NOP, KIND_IMAGE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, KIND_NONE, 32'd0, 1'b0, 32'd0);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0101);
    send_item(OP_ADD, KIND_OBJECT, 32'hA5A5_5A5A, 1'b1, 32'd0);
    send_item(OP_LOOKUP, KIND_OBJECT, 32'd0, 1'b0, 32'h0000_0201);
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct, input int count,
                                  input bit long_hold);
    send_idle_pct <= sender_pct;
    stall_pct <= receiver_pct;
    send_item(OP_CLEAR, pick_kind(), $urandom, 1'($urandom_range(0, 1)), $urandom);
    // Well-formed adds run the table to full and a little past it.
    repeat (SLOTS + 2) begin
      send_item(OP_ADD, KIND_W'($urandom_range(KIND_OBJECT, KIND_IMAGE)), random_payload(),
                1'b1, $urandom);
    end
    for (int n = 0; n < count; n++) begin
      if (long_hold && n == count / 2) hold_req <= ~hold_req;
      send_random_item();
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct <= 31;
    stall_pct <= 51;
    run_directed();
    run_random_phase(31, 51, 140, 1'b0);
    run_random_phase(51, 31, 140, 1'b0);
    run_random_phase(0, 0, 140, 1'b1);
    repeat (8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("generational_handle_table verification clean");
    end else begin
      $display("generational_handle_table verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/ght_pkg.sv
src/ght_slot_mem.sv
src/generational_handle_table.sv
tb/sv/ght_scoreboard_pkg.sv
tb/sv/generational_handle_table_tb.sv
